FILE: src/itoa_pkg.sv
// Shared types, constants and helpers for the integer-to-ASCII formatter.
// No dependencies; imported by every module of the block.
`default_nettype none

package itoa_pkg;

   localparam int VALUE_W     = 64;
   localparam int PAD_W       = 7;
   localparam int DEC_DIGITS  = 20;
   localparam int BCD_W       = 4 * DEC_DIGITS;
   localparam int LEN_W       = $clog2(DEC_DIGITS + 1);
   localparam int BIT_CNT_W   = $clog2(VALUE_W);
   localparam int QUEUE_DEPTH = 2;

   localparam logic [PAD_W-1:0] MAX_WIDTH = 7'd64;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_UPPER = 8'h41;
   localparam logic [7:0] CHAR_LOWER = 8'h61;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef enum logic [1:0] {
      KIND_SDEC,
      KIND_UDEC,
      KIND_LHEX,
      KIND_UHEX
   } kind_type;

   // one classified item waiting for the back end
   typedef struct packed {
      logic [VALUE_W-1:0] mag;
      logic               negative;
      logic               hex;
      logic               upper;
      logic [PAD_W-1:0]   width;
      logic               zeros;
   } job_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_NORMALIZE,
      ST_PAD_SPACE,
      ST_SIGN,
      ST_PAD_ZERO,
      ST_DIGITS
   } back_state_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] base_c;
      base_c = upper ? CHAR_UPPER : CHAR_LOWER;
      if (d < 4'd10) begin
         digit_char = CHAR_ZERO + {4'b0, d};
      end else begin
         digit_char = base_c + {4'b0, d} - 8'd10;
      end
   endfunction

endpackage

`default_nettype wire

FILE: src/integer_to_padded_ascii_core.sv
// Top level of the integer-to-ASCII formatter: front end, job queue, back end.
// Depends on itoa_pkg, itoa_front, itoa_queue and itoa_back.
//
//   channel  handshake            payload
//   -------  -------------------  -------------------------------------------
//   request  start / busy         req_type, req_value, req_wide_arg,
//                                 req_pad_width, req_zero_pad
//   result   rsp_valid (strobe)   rsp_out_char, rsp_last_char
//
// Cycles: an item is taken whenever start is high and busy is low; busy only
//   rises when the two-entry job queue is full.
// Back end per item: a load step, shift-and-add-3 over all 64 bits for
//   decimal (none for hex), up to 19 leading zeros stripped, then pad,
//   sign and digit characters one per cycle, with a bookkeeping step in the
//   normalize, pad and sign states (the sign state shows '-' when negative).
// Output: characters leave through one output register.
// Reset: synchronous, clears queue pointers, back-end state and the strobe.
// Stalls: the receiver cannot stall; each character shows for one cycle.
`default_nettype none

module integer_to_padded_ascii_core (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire  [1:0]                   req_type,
   input  wire  [itoa_pkg::VALUE_W-1:0] req_value,
   input  wire                          req_wide_arg,
   input  wire  [itoa_pkg::PAD_W-1:0]   req_pad_width,
   input  wire                          req_zero_pad,
   output logic                         rsp_valid,
   output logic [7:0]                   rsp_out_char,
   output logic                         rsp_last_char
);
   import itoa_pkg::*;

   job_type          front_job;
   job_type          queue_job;
   queue_status_type q_status;
   logic             push;
   logic             pop;

   // classify and push; busy mirrors a full queue
   itoa_front u_front (
      .start         (start),
      .queue_full    (q_status.full),
      .req_type      (req_type),
      .req_value     (req_value),
      .req_wide_arg  (req_wide_arg),
      .req_pad_width (req_pad_width),
      .req_zero_pad  (req_zero_pad),
      .push          (push),
      .job           (front_job)
   );

   itoa_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wr_job (front_job),
      .pop    (pop),
      .rd_job (queue_job),
      .status (q_status)
   );

   // back end pops one job at a time and owns the result strobe
   itoa_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .job           (queue_job),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

   assign busy = q_status.full;

endmodule

`default_nettype wire

FILE: src/itoa_front.sv
// Front end: narrows or sign-extends the argument, forms sign and magnitude,
// caps the width and pushes one job per accepted item. Uses itoa_pkg.
`default_nettype none

module itoa_front (
   input  wire                          start,
   input  wire                          queue_full,
   input  wire  [1:0]                   req_type,
   input  wire  [itoa_pkg::VALUE_W-1:0] req_value,
   input  wire                          req_wide_arg,
   input  wire  [itoa_pkg::PAD_W-1:0]   req_pad_width,
   input  wire                          req_zero_pad,
   output logic                         push,
   output itoa_pkg::job_type            job
);
   import itoa_pkg::*;

   kind_type           kind;
   logic [VALUE_W-1:0] arg;
   logic               neg;

   always_comb begin
      kind = kind_type'(req_type);
      if (req_wide_arg) begin
         arg = req_value;
      end else if (kind == KIND_SDEC) begin
         arg = {{(VALUE_W-32){req_value[31]}}, req_value[31:0]};
      end else begin
         arg = {{(VALUE_W-32){1'b0}}, req_value[31:0]};
      end
      neg = (kind == KIND_SDEC) && arg[VALUE_W-1];

      job.mag      = neg ? (~arg + {{(VALUE_W-1){1'b0}}, 1'b1}) : arg;
      job.negative = neg;
      job.hex      = (kind == KIND_LHEX) || (kind == KIND_UHEX);
      job.upper    = (kind == KIND_UHEX);
      job.width    = (req_pad_width > MAX_WIDTH) ? MAX_WIDTH : req_pad_width;
      job.zeros    = req_zero_pad;

      push = start && !queue_full;
   end

endmodule

`default_nettype wire

FILE: src/itoa_queue.sv
// Short job queue between front and back end.
// Depth from itoa_pkg::QUEUE_DEPTH; uses itoa_pkg job and status types.
`default_nettype none

module itoa_queue (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  itoa_pkg::job_type          wr_job,
   input  wire                        pop,
   output itoa_pkg::job_type          rd_job,
   output itoa_pkg::queue_status_type status
);
   import itoa_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   job_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
      status.full      = (count_ff == FULL_CNT);
      status.not_empty = (count_ff != '0);
      rd_job           = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_job;
      end
   end

endmodule

`default_nettype wire

FILE: src/itoa_back.sv
// Back end: shift-and-add-3 BCD (decimal only), leading-zero strip,
// emits pad, sign and digit characters one per cycle. Uses itoa_pkg.
`default_nettype none

module itoa_back (
   input  wire                        clock,
   input  wire                        reset,
   input  itoa_pkg::queue_status_type q_status,
   input  itoa_pkg::job_type          job,
   output logic                       pop,
   output logic                       rsp_valid,
   output logic [7:0]                 rsp_out_char,
   output logic                       rsp_last_char
);
   import itoa_pkg::*;

   localparam logic [LEN_W-1:0]     FULL_LEN = LEN_W'(DEC_DIGITS);
   localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(VALUE_W - 1);

   back_state_type       state_ff, state_in;
   logic [BCD_W-1:0]     bcd_ff, bcd_in;
   logic [VALUE_W-1:0]   mag_ff, mag_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [PAD_W-1:0]     pad_ff, pad_in;
   logic [PAD_W-1:0]     width_ff, width_in;
   logic                 neg_ff, neg_in;
   logic                 upper_ff, upper_in;
   logic                 zeros_ff, zeros_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [BCD_W-1:0]     bcd_adj;
   logic [PAD_W-1:0]     need;

   always_comb begin
      logic [3:0] nib;
      // add-3 correction on every BCD digit before the shift
      for (int i = 0; i < DEC_DIGITS; i++) begin
         nib = bcd_ff[4*i +: 4];
         bcd_adj[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
      end
      need = PAD_W'(len_ff) + PAD_W'(neg_ff);

      state_in     = state_ff;
      bcd_in       = bcd_ff;
      mag_in       = mag_ff;
      bit_cnt_in   = bit_cnt_ff;
      len_in       = len_ff;
      pad_in       = pad_ff;
      width_in     = width_ff;
      neg_in       = neg_ff;
      upper_in     = upper_ff;
      zeros_in     = zeros_ff;
      rsp_valid_in = 1'b0;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = 1'b0;
      pop          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_status.not_empty) begin
               pop        = 1'b1;
               mag_in     = job.mag;
               width_in   = job.width;
               neg_in     = job.negative;
               upper_in   = job.upper;
               zeros_in   = job.zeros;
               len_in     = FULL_LEN;
               bit_cnt_in = '0;
               if (job.hex) begin
                  bcd_in   = {{(BCD_W-VALUE_W){1'b0}}, job.mag};
                  state_in = ST_NORMALIZE;
               end else begin
                  bcd_in   = '0;
                  state_in = ST_CONVERT;
               end
            end
         end
         ST_CONVERT: begin
            bcd_in     = {bcd_adj[BCD_W-2:0], mag_ff[VALUE_W-1]};
            mag_in     = {mag_ff[VALUE_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == LAST_BIT) begin
               state_in = ST_NORMALIZE;
            end
         end
         ST_NORMALIZE: begin
            if ((len_ff > 1) && (bcd_ff[BCD_W-1 -: 4] == 4'd0)) begin
               bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
               len_in = len_ff - 1'b1;
            end else begin
               pad_in   = (width_ff > need) ? width_ff - need : '0;
               state_in = zeros_ff ? ST_SIGN : ST_PAD_SPACE;
            end
         end
         ST_PAD_SPACE: begin
            if (pad_ff != '0) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_SPACE;
               pad_in       = pad_ff - 1'b1;
            end else begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            if (neg_ff) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_MINUS;
            end
            state_in = zeros_ff ? ST_PAD_ZERO : ST_DIGITS;
         end
         ST_PAD_ZERO: begin
            if (pad_ff != '0) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_ZERO;
               pad_in       = pad_ff - 1'b1;
            end else begin
               state_in = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = digit_char(bcd_ff[BCD_W-1 -: 4], upper_ff);
            bcd_in       = {bcd_ff[BCD_W-5:0], 4'd0};
            len_in       = len_ff - 1'b1;
            if (len_ff == 1) begin
               rsp_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff      <= bcd_in;
      mag_ff      <= mag_in;
      bit_cnt_ff  <= bit_cnt_in;
      len_ff      <= len_in;
      pad_ff      <= pad_in;
      width_ff    <= width_in;
      neg_ff      <= neg_in;
      upper_ff    <= upper_in;
      zeros_ff    <= zeros_in;
      rsp_char_ff <= rsp_char_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_char  = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

   a_last_is_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_last_ff |-> rsp_valid_ff)
      else $error("last flag without a character");

   a_final_digit_marks_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGITS && len_ff == 1) |=> rsp_last_ff)
      else $error("final digit not marked last");

   a_mid_item_not_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (state_ff != ST_IDLE))
      else $error("back end idle with characters still owed");

   a_done_returns_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_last_ff |-> (state_ff == ST_IDLE))
      else $error("back end not idle after last character");

endmodule

`default_nettype wire
